// ----- rtl/tree_path_query_binary_lifting_top_assert.svh -----
// Assertion macros shared by the path query block.
`ifndef TREE_PATH_QUERY_BINARY_LIFTING_TOP_ASSERT_SVH
`define TREE_PATH_QUERY_BINARY_LIFTING_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tpq_pkg.sv -----
// Shared types, codes and arithmetic helpers of the path query block.
package tpq_pkg;

    localparam int WSUM_W = 40;
    localparam int NODE_PORT_W = 10;
    localparam int EDGE_W = 20;
    localparam int K_W = 11;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_DIST = 2'd1;
    localparam logic [1:0] MODE_KTH  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [WSUM_W-1:0] WMAX = {WSUM_W{1'b1}};

    typedef struct packed {
        logic                   bad;
        logic [NODE_PORT_W-1:0] node;
        logic [WSUM_W-1:0]      path_len;
    } result_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } status_t;

    function automatic logic [WSUM_W-1:0] sat_add(input logic [WSUM_W-1:0] x,
                                                  input logic [WSUM_W-1:0] y);
        logic [WSUM_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[WSUM_W] ? WMAX : s[WSUM_W-1:0];
    endfunction

endpackage

// ----- rtl/tree_path_query_binary_lifting_top.sv -----
// Top level of the binary-lifting path query block: memories, sequencer, output register.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  s_      | in        | node_a, node_b, edge_weight, kth_index      | mode
//  m_      | out       | path_distance, found_node                   | bad_query
//
//  After reset a clearing pass runs before s_tready rises.
//  A load's table fill after its transaction is bound by dependent table reads.
//  A query runs an upward lift, a paired search and, for kth queries, a k-th lift,
//  all sharing the single read port of the ancestor table.
//  One item is in work at a time; the output register holds one result while m_ stalls.
module tree_path_query_binary_lifting_top #(
    parameter int MAX_NODES = 1024,
    parameter int LOG_LEVELS = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // node_a[9:0], node_b[19:10], edge_weight[39:20], kth_index[50:40]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // path_distance[39:0], found_node[49:40]
    output logic [0:0]  m_tuser    // bad_query[0]
);

    `include "tree_path_query_binary_lifting_top_assert.svh"

    localparam int NW = $clog2(MAX_NODES);
    localparam int TAW = $clog2(MAX_NODES * LOG_LEVELS);
    localparam int TW = NW + tpq_pkg::WSUM_W;
    localparam int DMW = LOG_LEVELS + 2;

    tpq_pkg::status_t stat;
    tpq_pkg::result_t res;
    tpq_pkg::result_t out_reg;
    logic             out_valid_reg, out_valid_next;
    logic             res_valid, res_ready;

    logic             dep_we;
    logic [NW-1:0]    dep_waddr, dep_raddr;
    logic [DMW-1:0]   dep_wdata, dep_rdata;
    logic             tbl_we;
    logic [TAW-1:0]   tbl_waddr, tbl_raddr;
    logic [TW-1:0]    tbl_wdata, tbl_rdata;

    tpq_ram #(.WIDTH(DMW), .DEPTH(MAX_NODES)) u_dep_ram (
        .aclk(aclk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
        .raddr(dep_raddr), .rdata(dep_rdata)
    );

    tpq_ram #(.WIDTH(TW), .DEPTH(MAX_NODES * LOG_LEVELS)) u_tbl_ram (
        .aclk(aclk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
        .raddr(tbl_raddr), .rdata(tbl_rdata)
    );

    tpq_core #(.MAX_NODES(MAX_NODES), .LOG_LEVELS(LOG_LEVELS)) u_core (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(s_tvalid),
        .in_mode(s_tuser),
        .in_a(s_tdata[9:0]),
        .in_b(s_tdata[19:10]),
        .in_w(s_tdata[39:20]),
        .in_k(s_tdata[50:40]),
        .stat(stat),
        .res_valid(res_valid),
        .res(res),
        .res_ready(res_ready),
        .dep_we(dep_we),
        .dep_waddr(dep_waddr),
        .dep_wdata(dep_wdata),
        .dep_raddr(dep_raddr),
        .dep_rdata(dep_rdata),
        .tbl_we(tbl_we),
        .tbl_waddr(tbl_waddr),
        .tbl_wdata(tbl_wdata),
        .tbl_raddr(tbl_raddr),
        .tbl_rdata(tbl_rdata)
    );

    assign s_tready = stat.idle;
    assign res_ready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'd0, out_reg.node, out_reg.path_len};
    assign m_tuser = out_reg.bad;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    `TPQ_ASSERT_IMP(a_ready_clr, aclk, aresetn, s_tready, !stat.clearing, "ready in clearing")
    `TPQ_ASSERT_NXT(a_res_held, aclk, aresetn, res_valid && !res_ready, res_valid && $stable(res), "result lost")
    `TPQ_ASSERT_IMP(a_bad_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[49:0] == 50'd0, "bad with payload")
    `TPQ_ASSERT_IMP(a_one_field, aclk, aresetn, m_tvalid && m_tdata[39:0] != 40'd0, m_tdata[49:40] == 10'd0, "two fields")

endmodule

// ----- rtl/tpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/tpq_core.sv -----
// Sequencer for loads, lowest-common-ancestor search and k-th node lifting.
module tpq_core #(
    parameter int MAX_NODES = 1024,
    parameter int LOG_LEVELS = 11
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  logic [1:0]                        in_mode,
    input  logic [tpq_pkg::NODE_PORT_W-1:0]   in_a,
    input  logic [tpq_pkg::NODE_PORT_W-1:0]   in_b,
    input  logic [tpq_pkg::EDGE_W-1:0]        in_w,
    input  logic [tpq_pkg::K_W-1:0]           in_k,
    output tpq_pkg::status_t                  stat,
    output logic                              res_valid,
    output tpq_pkg::result_t                  res,
    input  logic                              res_ready,
    output logic                              dep_we,
    output logic [$clog2(MAX_NODES)-1:0]      dep_waddr,
    output logic [LOG_LEVELS+1:0]             dep_wdata,
    output logic [$clog2(MAX_NODES)-1:0]      dep_raddr,
    input  logic [LOG_LEVELS+1:0]             dep_rdata,
    output logic                              tbl_we,
    output logic [$clog2(MAX_NODES*LOG_LEVELS)-1:0] tbl_waddr,
    output logic [$clog2(MAX_NODES)+tpq_pkg::WSUM_W-1:0] tbl_wdata,
    output logic [$clog2(MAX_NODES*LOG_LEVELS)-1:0] tbl_raddr,
    input  logic [$clog2(MAX_NODES)+tpq_pkg::WSUM_W-1:0] tbl_rdata
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int TAW = $clog2(MAX_NODES * LOG_LEVELS);
    localparam int WW = tpq_pkg::WSUM_W;
    localparam int DEP_W = LOG_LEVELS + 1;
    localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int CNT_W = LOG_LEVELS + 2;
    localparam int CW = (CNT_W > tpq_pkg::K_W) ? CNT_W : tpq_pkg::K_W;
    localparam int CLR_LEN = (MAX_NODES > LOG_LEVELS) ? MAX_NODES : LOG_LEVELS;
    localparam int CLW = $clog2(CLR_LEN + 1);
    localparam logic [DEP_W-1:0] DEP_LIMIT = DEP_W'((1 << LOG_LEVELS) - 1);
    localparam logic [LW-1:0] LVL_TOP = LW'(LOG_LEVELS - 1);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_RDA  = 5'd2;
    localparam logic [4:0] S_RDB  = 5'd3;
    localparam logic [4:0] S_CHK  = 5'd4;
    localparam logic [4:0] S_LRD  = 5'd5;
    localparam logic [4:0] S_LWR  = 5'd6;
    localparam logic [4:0] S_URD  = 5'd7;
    localparam logic [4:0] S_UWB  = 5'd8;
    localparam logic [4:0] S_UEND = 5'd9;
    localparam logic [4:0] S_PA   = 5'd10;
    localparam logic [4:0] S_PB   = 5'd11;
    localparam logic [4:0] S_PC   = 5'd12;
    localparam logic [4:0] S_FA   = 5'd13;
    localparam logic [4:0] S_FB   = 5'd14;
    localparam logic [4:0] S_FC   = 5'd15;
    localparam logic [4:0] S_LCA  = 5'd16;
    localparam logic [4:0] S_KCHK = 5'd17;
    localparam logic [4:0] S_KCNT = 5'd18;
    localparam logic [4:0] S_KSEL = 5'd19;
    localparam logic [4:0] S_KRD  = 5'd20;
    localparam logic [4:0] S_KWB  = 5'd21;
    localparam logic [4:0] S_OUT  = 5'd22;

    function automatic logic [TAW-1:0] taddr(input logic [NW-1:0] n, input logic [LW-1:0] l);
        return TAW'(n) * TAW'(LOG_LEVELS) + TAW'(l);
    endfunction

    logic [4:0]             state_reg, state_next;
    logic [CLW-1:0]         clr_reg, clr_next;
    logic [1:0]             mode_reg, mode_next;
    logic [NW-1:0]          a_reg, a_next, b_reg, b_next;
    logic [NW-1:0]          x_reg, x_next, y_reg, y_next;
    logic [NW-1:0]          anc_a_reg, anc_a_next, lca_reg, lca_next;
    logic [tpq_pkg::EDGE_W-1:0] w_reg, w_next;
    logic [tpq_pkg::K_W-1:0]    k_reg, k_next;
    logic [DEP_W:0]         depa_reg, depa_next;
    logic [DEP_W-1:0]       depb_reg, depb_next;
    logic [LOG_LEVELS-1:0]  diff_reg, diff_next;
    logic [LOG_LEVELS-1:0]  da_reg, da_next, db_reg, db_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [WW-1:0]          d_reg, d_next, wa_reg, wa_next, wb_reg, wb_next;
    logic                   pend_reg, pend_next;
    logic [LW-1:0]          lvl_reg, lvl_next;
    tpq_pkg::result_t       res_reg, res_next;

    logic                   a_ok, b_ok;
    logic [NW-1:0]          t_anc;
    logic [WW-1:0]          t_w;
    logic [DEP_W-1:0]       rd_dep;
    logic                   rd_loaded;
    logic [CW-1:0]          kx, cx, km1;

    assign a_ok = {22'd0, in_a} < 32'(MAX_NODES);
    assign b_ok = {22'd0, in_b} < 32'(MAX_NODES);
    assign t_anc = tbl_rdata[NW+WW-1:WW];
    assign t_w = tbl_rdata[WW-1:0];
    assign rd_dep = dep_rdata[DEP_W-1:0];
    assign rd_loaded = dep_rdata[DEP_W];
    assign kx = CW'(k_reg);
    assign cx = CW'(cnt_reg);
    assign km1 = kx - CW'(1);

    assign stat.clearing = (state_reg == S_CLR);
    assign stat.idle = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res = res_reg;

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        mode_next = mode_reg;
        a_next = a_reg;
        b_next = b_reg;
        x_next = x_reg;
        y_next = y_reg;
        anc_a_next = anc_a_reg;
        lca_next = lca_reg;
        w_next = w_reg;
        k_next = k_reg;
        depa_next = depa_reg;
        depb_next = depb_reg;
        diff_next = diff_reg;
        da_next = da_reg;
        db_next = db_reg;
        cnt_next = cnt_reg;
        d_next = d_reg;
        wa_next = wa_reg;
        wb_next = wb_reg;
        pend_next = pend_reg;
        lvl_next = lvl_reg;
        res_next = res_reg;
        dep_we = 1'b0;
        dep_waddr = a_reg;
        dep_wdata = {1'b1, DEP_W'(depb_reg + DEP_W'(1))};
        dep_raddr = a_reg;
        tbl_we = 1'b0;
        tbl_waddr = taddr(a_reg, lvl_reg);
        tbl_wdata = {t_anc, tpq_pkg::sat_add(d_reg, t_w)};
        tbl_raddr = taddr(x_reg, lvl_reg);
        unique case (state_reg)
            S_CLR: begin
                dep_we = ({{(32-CLW){1'b0}}, clr_reg} < 32'(MAX_NODES));
                dep_waddr = NW'(clr_reg);
                dep_wdata = {1'b0, {DEP_W{1'b1}}};
                tbl_we = ({{(32-CLW){1'b0}}, clr_reg} < 32'(LOG_LEVELS));
                tbl_waddr = TAW'(clr_reg);
                tbl_wdata = '0;
                clr_next = clr_reg + CLW'(1);
                if (clr_reg == CLW'(CLR_LEN - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    mode_next = in_mode;
                    a_next = NW'(in_a);
                    b_next = NW'(in_b);
                    w_next = in_w;
                    k_next = in_k;
                    unique case (in_mode) inside
                        tpq_pkg::MODE_LOAD: begin
                            if (in_a != '0 && a_ok && b_ok) begin
                                state_next = S_RDA;
                            end
                        end
                        tpq_pkg::MODE_DIST, tpq_pkg::MODE_KTH: begin
                            if (in_a != '0 && in_b != '0 && a_ok && b_ok) begin
                                state_next = S_RDA;
                            end else begin
                                res_next = '{bad: 1'b1, node: '0, path_len: '0};
                                state_next = S_OUT;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDA: begin
                dep_raddr = a_reg;
                state_next = S_RDB;
            end
            S_RDB: begin
                dep_raddr = b_reg;
                depa_next = dep_rdata;
                state_next = S_CHK;
            end
            S_CHK: begin
                depb_next = rd_dep;
                if (mode_reg == tpq_pkg::MODE_LOAD) begin
                    if (depa_reg[DEP_W] || (b_reg != '0 && !rd_loaded) || rd_dep == DEP_LIMIT) begin
                        state_next = S_IDLE;
                    end else begin
                        dep_we = 1'b1;
                        dep_waddr = a_reg;
                        dep_wdata = {1'b1, DEP_W'(rd_dep + DEP_W'(1))};
                        tbl_we = 1'b1;
                        tbl_waddr = taddr(a_reg, '0);
                        tbl_wdata = {b_reg, WW'(w_reg)};
                        x_next = b_reg;
                        d_next = WW'(w_reg);
                        lvl_next = LW'(1);
                        state_next = (LOG_LEVELS == 1) ? S_IDLE : S_LRD;
                    end
                end else if (!depa_reg[DEP_W] || !rd_loaded) begin
                    res_next = '{bad: 1'b1, node: '0, path_len: '0};
                    state_next = S_OUT;
                end else begin
                    if (depa_reg[DEP_W-1:0] > rd_dep) begin
                        x_next = b_reg;
                        y_next = a_reg;
                        diff_next = LOG_LEVELS'(depa_reg[DEP_W-1:0] - rd_dep);
                    end else begin
                        x_next = a_reg;
                        y_next = b_reg;
                        diff_next = LOG_LEVELS'(rd_dep - depa_reg[DEP_W-1:0]);
                    end
                    d_next = '0;
                    lvl_next = LVL_TOP;
                    state_next = S_URD;
                end
            end
            S_LRD: begin
                tbl_raddr = taddr(x_reg, lvl_reg - LW'(1));
                state_next = S_LWR;
            end
            S_LWR: begin
                tbl_we = 1'b1;
                tbl_waddr = taddr(a_reg, lvl_reg);
                tbl_wdata = {t_anc, tpq_pkg::sat_add(d_reg, t_w)};
                x_next = t_anc;
                d_next = tpq_pkg::sat_add(d_reg, t_w);
                if (lvl_reg == LVL_TOP) begin
                    state_next = S_IDLE;
                end else begin
                    lvl_next = lvl_reg + LW'(1);
                    state_next = S_LRD;
                end
            end
            S_URD: begin
                tbl_raddr = taddr(y_reg, lvl_reg);
                if (diff_reg[lvl_reg]) begin
                    state_next = S_UWB;
                end else if (lvl_reg == '0) begin
                    state_next = S_UEND;
                end else begin
                    lvl_next = lvl_reg - LW'(1);
                end
            end
            S_UWB: begin
                d_next = tpq_pkg::sat_add(d_reg, t_w);
                y_next = t_anc;
                if (lvl_reg == '0) begin
                    state_next = S_UEND;
                end else begin
                    lvl_next = lvl_reg - LW'(1);
                    state_next = S_URD;
                end
            end
            S_UEND: begin
                if (x_reg == y_reg) begin
                    lca_next = x_reg;
                    state_next = S_LCA;
                end else begin
                    lvl_next = LVL_TOP;
                    pend_next = 1'b0;
                    state_next = S_PA;
                end
            end
            S_PA: begin
                if (pend_reg) begin
                    d_next = tpq_pkg::sat_add(d_reg, wb_reg);
                end
                pend_next = 1'b0;
                tbl_raddr = taddr(x_reg, lvl_reg);
                state_next = S_PB;
            end
            S_PB: begin
                anc_a_next = t_anc;
                wa_next = t_w;
                tbl_raddr = taddr(y_reg, lvl_reg);
                state_next = S_PC;
            end
            S_PC: begin
                if (anc_a_reg != t_anc) begin
                    d_next = tpq_pkg::sat_add(d_reg, wa_reg);
                    wb_next = t_w;
                    pend_next = 1'b1;
                    x_next = anc_a_reg;
                    y_next = t_anc;
                end
                if (lvl_reg == '0) begin
                    state_next = S_FA;
                end else begin
                    lvl_next = lvl_reg - LW'(1);
                    state_next = S_PA;
                end
            end
            S_FA: begin
                if (pend_reg) begin
                    d_next = tpq_pkg::sat_add(d_reg, wb_reg);
                end
                pend_next = 1'b0;
                tbl_raddr = taddr(x_reg, '0);
                state_next = S_FB;
            end
            S_FB: begin
                anc_a_next = t_anc;
                d_next = tpq_pkg::sat_add(d_reg, t_w);
                tbl_raddr = taddr(y_reg, '0);
                state_next = S_FC;
            end
            S_FC: begin
                d_next = tpq_pkg::sat_add(d_reg, t_w);
                lca_next = anc_a_reg;
                state_next = S_LCA;
            end
            S_LCA: begin
                dep_raddr = lca_reg;
                if (lca_reg == '0) begin
                    res_next = '{bad: 1'b1, node: '0, path_len: '0};
                    state_next = S_OUT;
                end else if (mode_reg == tpq_pkg::MODE_DIST) begin
                    res_next = '{bad: 1'b0, node: '0, path_len: d_reg};
                    state_next = S_OUT;
                end else begin
                    state_next = S_KCHK;
                end
            end
            S_KCHK: begin
                da_next = LOG_LEVELS'(depa_reg[DEP_W-1:0] - rd_dep);
                db_next = LOG_LEVELS'(depb_reg - rd_dep);
                state_next = S_KCNT;
            end
            S_KCNT: begin
                cnt_next = CNT_W'(da_reg) + CNT_W'(db_reg) + CNT_W'(1);
                state_next = S_KSEL;
            end
            S_KSEL: begin
                lvl_next = LVL_TOP;
                if (k_reg == '0 || kx > cx) begin
                    res_next = '{bad: 1'b1, node: '0, path_len: '0};
                    state_next = S_OUT;
                end else if (km1 <= CW'(da_reg)) begin
                    y_next = a_reg;
                    diff_next = LOG_LEVELS'(km1);
                    state_next = S_KRD;
                end else begin
                    y_next = b_reg;
                    diff_next = LOG_LEVELS'(cx - kx);
                    state_next = S_KRD;
                end
            end
            S_KRD: begin
                tbl_raddr = taddr(y_reg, lvl_reg);
                if (diff_reg[lvl_reg]) begin
                    state_next = S_KWB;
                end else if (lvl_reg == '0) begin
                    res_next = '{bad: 1'b0, node: tpq_pkg::NODE_PORT_W'(y_reg), path_len: '0};
                    state_next = S_OUT;
                end else begin
                    lvl_next = lvl_reg - LW'(1);
                end
            end
            S_KWB: begin
                y_next = t_anc;
                if (lvl_reg == '0) begin
                    res_next = '{bad: 1'b0, node: tpq_pkg::NODE_PORT_W'(t_anc), path_len: '0};
                    state_next = S_OUT;
                end else begin
                    lvl_next = lvl_reg - LW'(1);
                    state_next = S_KRD;
                end
            end
            S_OUT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            pend_reg <= pend_next;
        end
        mode_reg <= mode_next;
        a_reg <= a_next;
        b_reg <= b_next;
        x_reg <= x_next;
        y_reg <= y_next;
        anc_a_reg <= anc_a_next;
        lca_reg <= lca_next;
        w_reg <= w_next;
        k_reg <= k_next;
        depa_reg <= depa_next;
        depb_reg <= depb_next;
        diff_reg <= diff_next;
        da_reg <= da_next;
        db_reg <= db_next;
        cnt_reg <= cnt_next;
        d_reg <= d_next;
        wa_reg <= wa_next;
        wb_reg <= wb_next;
        lvl_reg <= lvl_next;
        res_reg <= res_next;
    end

endmodule

// ----- tb/sv/tree_path_query_binary_lifting_top_tb.sv -----
// Self-checking testbench of the binary-lifting path query block: tree loads, distance and kth queries.
module tree_path_query_binary_lifting_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 1024;
    localparam int LEVELS = 11;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic                            bad;
        logic [tpq_pkg::NODE_PORT_W-1:0] node;
        logic [tpq_pkg::WSUM_W-1:0]      path_len;
    } path_answer_t;

    class path_scoreboard;
        logic [9:0]  anc_tab [NODES*LEVELS];
        logic [39:0] wsum_tab [NODES*LEVELS];
        int          node_depth [NODES];
        bit          is_loaded [NODES];
        path_answer_t pending [$];
        int          errors;
        int          answers;

        function new();
            foreach (anc_tab[i]) begin
                anc_tab[i] = '0;
                wsum_tab[i] = '0;
            end
            foreach (node_depth[i]) begin
                node_depth[i] = 0;
                is_loaded[i] = 0;
            end
            node_depth[0] = -1;
            errors = 0;
            answers = 0;
        endfunction

        function logic [9:0] climb(logic [9:0] x, int steps);
            for (int i = LEVELS - 1; i >= 0; i--)
                if ((steps >> i) & 1) x = anc_tab[x*LEVELS+i];
            return x;
        endfunction

        function logic [9:0] meet(logic [9:0] a, logic [9:0] b, output logic [39:0] d);
            logic [9:0] t, up;
            d = '0;
            if (node_depth[a] > node_depth[b]) begin
                t = a; a = b; b = t;
            end
            for (int i = LEVELS - 1; i >= 0; i--) begin
                up = anc_tab[b*LEVELS+i];
                if (node_depth[a] <= node_depth[up]) begin
                    d = tpq_pkg::sat_add(d, wsum_tab[b*LEVELS+i]);
                    b = up;
                end
            end
            if (a == b) return a;
            for (int i = LEVELS - 1; i >= 0; i--) begin
                if (anc_tab[a*LEVELS+i] != anc_tab[b*LEVELS+i]) begin
                    d = tpq_pkg::sat_add(d, wsum_tab[a*LEVELS+i]);
                    d = tpq_pkg::sat_add(d, wsum_tab[b*LEVELS+i]);
                    a = anc_tab[a*LEVELS+i];
                    b = anc_tab[b*LEVELS+i];
                end
            end
            d = tpq_pkg::sat_add(d, wsum_tab[a*LEVELS]);
            d = tpq_pkg::sat_add(d, wsum_tab[b*LEVELS]);
            return anc_tab[a*LEVELS];
        endfunction

        function void note_input(logic [1:0] mode, logic [9:0] a, logic [9:0] b,
                                 logic [19:0] w, logic [10:0] k);
            path_answer_t r;
            logic [9:0] l, mid;
            logic [39:0] d;
            int da, db, cnt;
            r = '0;
            if (mode == tpq_pkg::MODE_LOAD) begin
                if (a == 0 || is_loaded[a] || (b != 0 && !is_loaded[b])) return;
                if (node_depth[b] + 1 > (1 << LEVELS) - 1) return;
                node_depth[a] = node_depth[b] + 1;
                anc_tab[a*LEVELS] = b;
                wsum_tab[a*LEVELS] = {20'd0, w};
                for (int i = 1; i < LEVELS; i++) begin
                    mid = anc_tab[a*LEVELS+i-1];
                    anc_tab[a*LEVELS+i] = anc_tab[mid*LEVELS+i-1];
                    wsum_tab[a*LEVELS+i] = tpq_pkg::sat_add(wsum_tab[a*LEVELS+i-1],
                                                            wsum_tab[mid*LEVELS+i-1]);
                end
                is_loaded[a] = 1;
                return;
            end
            if (mode == tpq_pkg::MODE_NONE) return;
            if (a == 0 || b == 0 || !is_loaded[a] || !is_loaded[b]) begin
                r.bad = 1;
            end else begin
                l = meet(a, b, d);
                if (l == 0) r.bad = 1;
                else if (mode == tpq_pkg::MODE_DIST) r.path_len = d;
                else begin
                    da = node_depth[a] - node_depth[l];
                    db = node_depth[b] - node_depth[l];
                    cnt = da + db + 1;
                    if (k == 0 || k > cnt) r.bad = 1;
                    else if (k - 1 <= da) r.node = climb(a, k - 1);
                    else r.node = climb(b, cnt - k);
                end
            end
            pending = {pending, r};
        endfunction

        function void check_result(path_answer_t got);
            path_answer_t exp_r;
            answers++;
            if (pending.size() == 0) begin
                report("result with nothing pending", 0, got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.path_len !== exp_r.path_len)
                report("path_distance", exp_r.path_len, got.path_len);
            if (got.node !== exp_r.node) report("found_node", exp_r.node, got.node);
            if (got.bad !== exp_r.bad) report("bad_query", exp_r.bad, got.bad);
        endfunction

        function void report(string what, logic [63:0] want, logic [63:0] seen);
            errors++;
            if (errors <= 30)
                $display("mismatch %0s: expected %0h got %0h (result %0d)",
                         what, want, seen, answers);
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;

    path_scoreboard sb = new();
    int idle_cycles = 0;
    bit hold_off = 0;
    int loads_sent = 0, queries_sent = 0;
    logic [9:0] tree_nodes [$];

    tree_path_query_binary_lifting_top dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task send_item(logic [1:0] mode, logic [9:0] a, logic [9:0] b,
                   logic [19:0] w, logic [10:0] k, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g != 0) s_tvalid <= 0;
        repeat (g) @(posedge aclk);
        s_tvalid <= 1;
        s_tuser <= mode;
        s_tdata <= {5'd0, k, w, b, a};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(mode, a, b, w, k);
        if (mode == tpq_pkg::MODE_LOAD) loads_sent++;
        else queries_sent++;
    endtask

    task load_node(logic [9:0] a, logic [9:0] p, logic [19:0] w, bit gaps);
        if (a != 0 && !sb.is_loaded[a] && (p == 0 || sb.is_loaded[p]))
            tree_nodes = {tree_nodes, a};
        send_item(tpq_pkg::MODE_LOAD, a, p, w, 11'd0, gaps);
    endtask

    function logic [9:0] pick_node();
        if (tree_nodes.size() == 0 || $urandom_range(0, 9) == 0)
            return 10'($urandom_range(0, 1023));
        return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
    endfunction

    function logic [19:0] pick_weight();
        case ($urandom_range(0, 3))
            0: return 20'hFFFFF;
            1: return 20'd0;
            default: return 20'($urandom);
        endcase
    endfunction

    task query(bit gaps);
        logic [9:0] a, b;
        logic [10:0] k;
        a = pick_node();
        b = pick_node();
        case ($urandom_range(0, 5))
            0: k = 11'($urandom_range(0, 2047));
            1: k = 11'd0;
            default: k = 11'($urandom_range(1, 40));
        endcase
        send_item($urandom_range(0, 1) ? tpq_pkg::MODE_DIST : tpq_pkg::MODE_KTH, a, b,
                  20'($urandom), k, gaps);
    endtask

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_result({m_tuser[0], m_tdata[49:40], m_tdata[39:0]});
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int g;
        wait (aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 0;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            g = gap_len();
            if (g == 0 || $urandom_range(0, 2) == 0) begin
                m_tready <= 1;
                @(posedge aclk);
            end else begin
                m_tready <= 0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    initial begin
        logic [9:0] p;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        // directed: a chain, all-ones weights, bad loads, edge queries
        load_node(10'd1, 10'd0, 20'hFFFFF, 0);
        for (int i = 2; i <= 8; i++) load_node(10'(i), 10'(i - 1), 20'hFFFFF, 0);
        load_node(10'd1023, 10'd1, 20'h00001, 0);
        load_node(10'd9, 10'd0, 20'd0, 0);
        load_node(10'd0, 10'd0, 20'd5, 0);
        load_node(10'd3, 10'd1, 20'd5, 0);
        load_node(10'd500, 10'd700, 20'd5, 0);
        send_item(tpq_pkg::MODE_NONE, 10'd1, 10'd2, 20'd3, 11'd4, 0);
        send_item(tpq_pkg::MODE_DIST, 10'd8, 10'd1023, 20'd0, 11'd0, 0);
        send_item(tpq_pkg::MODE_DIST, 10'd8, 10'd8, 20'd0, 11'd0, 0);
        send_item(tpq_pkg::MODE_DIST, 10'd0, 10'd8, 20'd0, 11'd0, 0);
        send_item(tpq_pkg::MODE_DIST, 10'd8, 10'd9, 20'd0, 11'd0, 0);
        send_item(tpq_pkg::MODE_DIST, 10'd700, 10'd8, 20'd0, 11'd0, 0);
        send_item(tpq_pkg::MODE_KTH, 10'd8, 10'd1023, 20'd0, 11'd1, 0);
        send_item(tpq_pkg::MODE_KTH, 10'd8, 10'd1023, 20'd0, 11'd9, 0);
        send_item(tpq_pkg::MODE_KTH, 10'd8, 10'd1023, 20'd0, 11'd10, 0);
        send_item(tpq_pkg::MODE_KTH, 10'd8, 10'd1023, 20'd0, 11'd0, 0);
        send_item(tpq_pkg::MODE_KTH, 10'd8, 10'd1023, 20'd0, 11'd2047, 0);
        send_item(tpq_pkg::MODE_KTH, 10'd1023, 10'd8, 20'd0, 11'd3, 0);
        // press: receiver stalls while sender keeps offering queries
        hold_off = 1;
        for (int i = 0; i < 12; i++) query(0);
        // random: build trees with queries mixed in
        for (int n = 0; n < 530; n++) begin
            if ($urandom_range(0, 99) < 45) begin
                if ($urandom_range(0, 19) == 0) p = 10'($urandom_range(0, 1023));
                else if (tree_nodes.size() == 0 || $urandom_range(0, 15) == 0) p = 10'd0;
                else if ($urandom_range(0, 2) == 0) p = tree_nodes[tree_nodes.size() - 1];
                else p = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
                load_node(10'($urandom_range(1, 1023)), p, pick_weight(), 1);
            end else if ($urandom_range(0, 29) == 0) begin
                send_item(tpq_pkg::MODE_NONE, 10'($urandom), 10'($urandom), 20'($urandom),
                          11'($urandom), 1);
            end else begin
                query(1);
            end
        end
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("run: %0d loads, %0d queries, %0d results checked, %0d tree nodes",
                 loads_sent, queries_sent, sb.answers, tree_nodes.size());
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- tree_path_query_binary_lifting_top.f -----
+incdir+rtl
rtl/tpq_pkg.sv
rtl/tpq_ram.sv
rtl/tpq_core.sv
rtl/tree_path_query_binary_lifting_top.sv
tb/sv/tree_path_query_binary_lifting_top_tb.sv
